[hdl/prsu_pkg.sv]
package prsu_pkg;

   localparam int DEFAULT_MAX_WIDTH = 1024;
   localparam int DEFAULT_MAX_SCALE = 100;

   localparam int SCALE_BITS = 7;
   localparam int WIDTH_BITS = 11;
   localparam int HEIGHT_BITS = 16;
   localparam int CSR_DATA_BITS = 16;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCALE_FACTOR = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_WIDTH = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_HEIGHT = 2'd2;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_REQUEST = 1'b1;

   typedef enum logic [1:0] {
      STATUS_LOAD_DONE = 2'd0,
      STATUS_PIXEL = 2'd1,
      STATUS_LOAD_REFUSED = 2'd2,
      STATUS_NO_ROW = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

endpackage

[hdl/pixel_replication_upscaler.sv]
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_ready   req_operation, req_blue_in, req_green_in, req_red_in
// rsp       out        rsp_valid/rsp_ready   rsp_status, rsp_*_out, rsp_pad_bytes, rsp_*_last
// csr       in         csr_write_enable      csr_index, csr_write_data
//
// Every accepted word yields one result word in the next cycle; one word per cycle is
// sustained while rsp_ready is high. The figure is set by the single line buffer access per
// word, whose read is issued ahead at the next replay column. Reset is synchronous; it clears
// the counters and the result valid flag and sets each configuration register to one; the line
// buffer is not cleared. req_ready drops only while a result waits and rsp_ready is low.
module pixel_replication_upscaler #(
   parameter int MAX_WIDTH = prsu_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_SCALE = prsu_pkg::DEFAULT_MAX_SCALE
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_operation,
   input  logic [7:0]                          req_blue_in,
   input  logic [7:0]                          req_green_in,
   input  logic [7:0]                          req_red_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic [7:0]                          rsp_blue_out,
   output logic [7:0]                          rsp_green_out,
   output logic [7:0]                          rsp_red_out,
   output logic [1:0]                          rsp_pad_bytes,
   output logic                                rsp_row_last,
   output logic                                rsp_image_last,
   input  logic                                csr_write_enable,
   input  logic [prsu_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [prsu_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CW = (AW > prsu_pkg::WIDTH_BITS) ? prsu_pkg::WIDTH_BITS : AW;
   localparam int SW_RAW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
   localparam int SW = (SW_RAW > prsu_pkg::SCALE_BITS) ? prsu_pkg::SCALE_BITS : SW_RAW;
   localparam logic [prsu_pkg::WIDTH_BITS-1:0] WIDTH_LAST = prsu_pkg::WIDTH_BITS'(MAX_WIDTH - 1);
   localparam logic [prsu_pkg::SCALE_BITS-1:0] SCALE_LAST = prsu_pkg::SCALE_BITS'(MAX_SCALE - 1);

   logic [prsu_pkg::SCALE_BITS-1:0]  scale_factor_ff;
   logic [prsu_pkg::WIDTH_BITS-1:0]  source_width_ff;
   logic [prsu_pkg::HEIGHT_BITS-1:0] source_height_ff;

   logic [CW-1:0]                    load_column_ff, load_column_in;
   logic [CW-1:0]                    replay_column_ff, replay_column_in;
   logic [SW-1:0]                    across_repeat_ff, across_repeat_in;
   logic [SW-1:0]                    down_repeat_ff, down_repeat_in;
   logic [prsu_pkg::HEIGHT_BITS-1:0] row_count_ff, row_count_in;
   logic                             row_ready_ff, row_ready_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   prsu_pkg::status_type             rsp_status_ff, rsp_status_in;
   prsu_pkg::pixel_type              rsp_pixel_ff, rsp_pixel_in;
   logic [1:0]                       rsp_pad_bytes_ff, rsp_pad_bytes_in;
   logic                             rsp_row_last_ff, rsp_row_last_in;
   logic                             rsp_image_last_ff, rsp_image_last_in;

   logic [prsu_pkg::WIDTH_BITS-1:0]  width_last;
   logic [prsu_pkg::SCALE_BITS-1:0]  scale_last;
   logic [prsu_pkg::HEIGHT_BITS-1:0] height_last;
   logic [1:0]                       width_low;
   logic [1:0]                       scale_low;
   logic [3:0]                       pad_product;

   logic                             accept;
   logic                             buffer_write;
   prsu_pkg::pixel_type              load_pixel;
   prsu_pkg::pixel_type              buffer_pixel;

   // Effective configuration after range correction.
   always_comb begin
      if (source_width_ff == '0) begin
         width_last = '0;
      end else if (32'(source_width_ff) > 32'(MAX_WIDTH)) begin
         width_last = WIDTH_LAST;
      end else begin
         width_last = source_width_ff - 1'b1;
      end
      if (scale_factor_ff == '0) begin
         scale_last = '0;
      end else if (32'(scale_factor_ff) > 32'(MAX_SCALE)) begin
         scale_last = SCALE_LAST;
      end else begin
         scale_last = scale_factor_ff - 1'b1;
      end
      if (source_height_ff == '0) begin
         height_last = '0;
      end else begin
         height_last = source_height_ff - 1'b1;
      end
      width_low = width_last[1:0] + 2'd1;
      scale_low = scale_last[1:0] + 2'd1;
      pad_product = {2'b00, width_low} * {2'b00, scale_low};
   end

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept = req_valid && req_ready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   assign load_pixel.red = req_red_in;
   assign load_pixel.green = req_green_in;
   assign load_pixel.blue = req_blue_in;

   always_comb begin
      load_column_in = load_column_ff;
      replay_column_in = replay_column_ff;
      across_repeat_in = across_repeat_ff;
      down_repeat_in = down_repeat_ff;
      row_count_in = row_count_ff;
      row_ready_in = row_ready_ff;
      buffer_write = 1'b0;
      rsp_status_in = prsu_pkg::STATUS_LOAD_DONE;
      rsp_pixel_in = '0;
      rsp_pad_bytes_in = 2'd0;
      rsp_row_last_in = 1'b0;
      rsp_image_last_in = 1'b0;
      if (accept) begin
         if (req_operation == prsu_pkg::OP_LOAD) begin
            if (row_ready_ff) begin
               rsp_status_in = prsu_pkg::STATUS_LOAD_REFUSED;
            end else begin
               rsp_status_in = prsu_pkg::STATUS_LOAD_DONE;
               buffer_write = 1'b1;
               if (prsu_pkg::WIDTH_BITS'(load_column_ff) >= width_last) begin
                  load_column_in = '0;
                  replay_column_in = '0;
                  across_repeat_in = '0;
                  down_repeat_in = '0;
                  row_ready_in = 1'b1;
               end else begin
                  load_column_in = load_column_ff + 1'b1;
               end
            end
         end else if (!row_ready_ff) begin
            rsp_status_in = prsu_pkg::STATUS_NO_ROW;
         end else begin
            rsp_status_in = prsu_pkg::STATUS_PIXEL;
            rsp_pixel_in = buffer_pixel;
            if (prsu_pkg::SCALE_BITS'(across_repeat_ff) >= scale_last) begin
               across_repeat_in = '0;
               if (prsu_pkg::WIDTH_BITS'(replay_column_ff) >= width_last) begin
                  replay_column_in = '0;
                  rsp_pad_bytes_in = pad_product[1:0];
                  rsp_row_last_in = 1'b1;
                  if (prsu_pkg::SCALE_BITS'(down_repeat_ff) >= scale_last) begin
                     down_repeat_in = '0;
                     row_ready_in = 1'b0;
                     if (row_count_ff >= height_last) begin
                        rsp_image_last_in = 1'b1;
                        row_count_in = '0;
                     end else begin
                        row_count_in = row_count_ff + 1'b1;
                     end
                  end else begin
                     down_repeat_in = down_repeat_ff + 1'b1;
                  end
               end else begin
                  replay_column_in = replay_column_ff + 1'b1;
               end
            end else begin
               across_repeat_in = across_repeat_ff + 1'b1;
            end
         end
      end
   end

   // The buffer is read at the column the next request will replay.
   prsu_line_buffer #(
      .DEPTH(MAX_WIDTH)
   ) u_line_buffer (
      .clock   (clock),
      .wr_en   (buffer_write),
      .wr_addr (AW'(load_column_ff)),
      .wr_data (load_pixel),
      .rd_addr (AW'(replay_column_in)),
      .rd_data (buffer_pixel)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_factor_ff <= prsu_pkg::SCALE_BITS'(1);
         source_width_ff <= prsu_pkg::WIDTH_BITS'(1);
         source_height_ff <= prsu_pkg::HEIGHT_BITS'(1);
      end else if (csr_write_enable) begin
         case (csr_index)
            prsu_pkg::CSR_SCALE_FACTOR: begin
               scale_factor_ff <= csr_write_data[prsu_pkg::SCALE_BITS-1:0];
            end
            prsu_pkg::CSR_SOURCE_WIDTH: begin
               source_width_ff <= csr_write_data[prsu_pkg::WIDTH_BITS-1:0];
            end
            prsu_pkg::CSR_SOURCE_HEIGHT: begin
               source_height_ff <= csr_write_data[prsu_pkg::HEIGHT_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_column_ff <= '0;
         replay_column_ff <= '0;
         across_repeat_ff <= '0;
         down_repeat_ff <= '0;
         row_count_ff <= '0;
         row_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         load_column_ff <= load_column_in;
         replay_column_ff <= replay_column_in;
         across_repeat_ff <= across_repeat_in;
         down_repeat_ff <= down_repeat_in;
         row_count_ff <= row_count_in;
         row_ready_ff <= row_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_pixel_ff <= rsp_pixel_in;
         rsp_pad_bytes_ff <= rsp_pad_bytes_in;
         rsp_row_last_ff <= rsp_row_last_in;
         rsp_image_last_ff <= rsp_image_last_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_blue_out = rsp_pixel_ff.blue;
   assign rsp_green_out = rsp_pixel_ff.green;
   assign rsp_red_out = rsp_pixel_ff.red;
   assign rsp_pad_bytes = rsp_pad_bytes_ff;
   assign rsp_row_last = rsp_row_last_ff;
   assign rsp_image_last = rsp_image_last_ff;

endmodule

[hdl/prsu_line_buffer.sv]
module prsu_line_buffer #(
   parameter int DEPTH = prsu_pkg::DEFAULT_MAX_WIDTH,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  prsu_pkg::pixel_type wr_data,
   input  logic [AW-1:0]       rd_addr,
   output prsu_pkg::pixel_type rd_data
);

   prsu_pkg::pixel_type mem [DEPTH];
   prsu_pkg::pixel_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // A read of the address being written returns the new pixel.
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
